@@ sv/dei_pkg.sv @@
// ============================================================================
// Discharge energy integrator package
// Shared types, field widths and event kind codes.
// ============================================================================
`default_nettype none

package dei_pkg;

	// Event kind codes.
	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_UNPLUG = 3'd1;
	localparam logic [2:0] KIND_PLUG   = 3'd2;
	localparam logic [2:0] KIND_SLEEP  = 3'd3;
	localparam logic [2:0] KIND_WAKE   = 3'd4;

	// Field types.
	typedef logic [2:0]         kind_t;
	typedef logic [31:0]        ts_t;
	typedef logic signed [31:0] pwr_t;
	typedef logic [47:0]        sec_t;
	typedef logic [62:0]        en_t;

	// One classified segment: counted length, discharge magnitude, session end.
	typedef struct packed {
		logic [31:0] dt;
		logic [31:0] mag;
		logic        clear;
	} seg_t;

	// Queue write side and read side.
	typedef struct packed {
		logic valid;
		seg_t seg;
	} q_port_t;

endpackage

`default_nettype wire

@@ sv/dei_if.sv @@
// ============================================================================
// Discharge energy integrator channels
// Valid/ready channels for events, totals and the configuration write.
// ============================================================================
`default_nettype none

// Power event channel.
interface dei_event_if;
	logic            valid;
	logic            ready;
	dei_pkg::kind_t  event_kind;
	dei_pkg::ts_t    timestamp;
	dei_pkg::pwr_t   power_uw;

	modport source (output valid, event_kind, timestamp, power_uw, input ready);
	modport sink   (input valid, event_kind, timestamp, power_uw, output ready);
endinterface

// Totals result channel.
interface dei_totals_if;
	logic          valid;
	logic          ready;
	dei_pkg::sec_t session_seconds;
	dei_pkg::en_t  energy_uws;

	modport source (output valid, session_seconds, energy_uws, input ready);
	modport sink   (input valid, session_seconds, energy_uws, output ready);
endinterface

// Configuration write channel for the whole_ledger register.
interface dei_cfg_if;
	logic valid;
	logic ready;
	logic whole_ledger;

	modport source (output valid, whole_ledger, input ready);
	modport sink   (input valid, whole_ledger, output ready);
endinterface

`default_nettype wire

@@ sv/dei_front.sv @@
// ============================================================================
// Discharge energy integrator front end
// Holds the previous event and classifies each new pair into a segment.
// ============================================================================
`default_nettype none

module dei_front (
	input  wire              clk,
	input  wire              arst_n,
	dei_event_if.sink        evt,
	dei_cfg_if.sink          cfg,
	output dei_pkg::q_port_t q_wr,
	input  wire              q_full
);

	logic          whole_ledger_q;
	logic          has_prev_q;
	dei_pkg::kind_t prev_kind_q;
	dei_pkg::ts_t  prev_ts_q;
	dei_pkg::pwr_t prev_pwr_q;

	logic          accept;
	logic          counts;
	logic [31:0]   dt;
	logic [31:0]   mag_raw;

	assign cfg.ready = 1'b1;
	assign evt.ready = ~q_full;
	assign accept    = evt.valid & ~q_full;

	// Classify the segment between the stored event and the incoming one.
	always_comb begin
		counts  = has_prev_q
			&& (prev_kind_q != dei_pkg::KIND_SLEEP)
			&& (prev_kind_q != dei_pkg::KIND_PLUG)
			&& (evt.event_kind != dei_pkg::KIND_WAKE)
			&& (evt.timestamp > prev_ts_q);
		dt      = evt.timestamp - prev_ts_q;
		mag_raw = ~prev_pwr_q + 32'd1;

		q_wr.valid     = evt.valid;
		q_wr.seg.dt    = counts ? dt : 32'd0;
		q_wr.seg.mag   = (counts && prev_pwr_q[31]) ? mag_raw : 32'd0;
		q_wr.seg.clear = (evt.event_kind == dei_pkg::KIND_UNPLUG) && !whole_ledger_q;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_ledger_q <= 1'b0;
		end else if (cfg.valid) begin
			whole_ledger_q <= cfg.whole_ledger;
		end
	end

	// Previous event storage, updated on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_prev_q  <= 1'b0;
			prev_kind_q <= dei_pkg::KIND_TICK;
			prev_ts_q   <= '0;
			prev_pwr_q  <= '0;
		end else if (accept) begin
			has_prev_q  <= 1'b1;
			prev_kind_q <= evt.event_kind;
			prev_ts_q   <= evt.timestamp;
			prev_pwr_q  <= evt.power_uw;
		end
	end

endmodule

`default_nettype wire

@@ sv/dei_fifo.sv @@
// ============================================================================
// Discharge energy integrator segment queue
// Two-entry queue that decouples the front end from the accumulator.
// ============================================================================
`default_nettype none

module dei_fifo (
	input  wire              clk,
	input  wire              arst_n,
	input  dei_pkg::q_port_t q_wr,
	output logic             q_full,
	output dei_pkg::q_port_t q_rd,
	input  wire              q_pop
);

	dei_pkg::seg_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign q_full     = count_q[1];
	assign push       = q_wr.valid & ~count_q[1];
	assign pop        = q_pop & (count_q != 2'd0);
	assign q_rd.valid = (count_q != 2'd0);
	assign q_rd.seg   = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= q_wr.seg;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/dei_back.sv @@
// ============================================================================
// Discharge energy integrator back end
// Multiplies each segment's magnitude by its length and accumulates totals.
// ============================================================================
`default_nettype none

module dei_back (
	input  wire              clk,
	input  wire              arst_n,
	input  dei_pkg::q_port_t q_rd,
	output logic             q_pop,
	dei_totals_if.source     tot
);

	logic          valid_s1;
	logic [31:0]   dt_s1;
	logic [62:0]   prod_s1;
	logic          clear_s1;

	logic          out_valid_q;
	dei_pkg::sec_t sec_q;
	dei_pkg::en_t  en_q;

	logic          adv;
	logic [63:0]   prod;
	logic [48:0]   sec_sum;
	logic [63:0]   en_sum;
	dei_pkg::sec_t sec_next;
	dei_pkg::en_t  en_next;

	assign adv   = valid_s1 & (~out_valid_q | tot.ready);
	assign q_pop = q_rd.valid & (~valid_s1 | adv);
	assign prod  = 64'(q_rd.seg.mag) * 64'(q_rd.seg.dt);

	assign tot.valid           = out_valid_q;
	assign tot.session_seconds = sec_q;
	assign tot.energy_uws      = en_q;

	// Saturating accumulation, then the session clear on unplug.
	always_comb begin
		sec_sum  = {1'b0, sec_q} + 49'(dt_s1);
		en_sum   = {1'b0, en_q} + {1'b0, prod_s1};
		sec_next = sec_sum[48] ? '1 : sec_sum[47:0];
		en_next  = en_sum[63] ? '1 : en_sum[62:0];
		if (clear_s1) begin
			sec_next = '0;
			en_next  = '0;
		end
	end

	// Multiply stage payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			dt_s1    <= q_rd.seg.dt;
			prod_s1  <= prod[62:0];
			clear_s1 <= q_rd.seg.clear;
		end
	end

	// Multiply stage occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (q_pop || adv) begin
			valid_s1 <= q_pop;
		end
	end

	// Totals and the output register they feed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q       <= '0;
			en_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				sec_q       <= sec_next;
				en_q        <= en_next;
				out_valid_q <= 1'b1;
			end else if (tot.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/discharge_energy_integrator.sv @@
// ============================================================================
// Discharge energy integrator
// Left Riemann-sum integration of battery discharge over a power event stream.
// ============================================================================
// The block accepts one power event per clock cycle while the queue has room
// and returns one totals transaction per event: the counted seconds and the
// discharged energy in microwatt-seconds after that event. Each segment is
// registered in the queue, the multiply stage and the totals register in turn.
// The rate is set by the 32x32 multiply stage and the saturating accumulator
// update; a two-entry queue between the front end and the accumulator lets
// either side stall without losing events. The user must write the whole_ledger
// register only while no event is in flight; the block does not enforce it.
`default_nettype none

module discharge_energy_integrator (
	input  wire          clk,
	input  wire          arst_n,
	dei_event_if.sink    evt,
	dei_cfg_if.sink      cfg,
	dei_totals_if.source tot
);

	dei_pkg::q_port_t q_wr;
	dei_pkg::q_port_t q_rd;
	logic             q_full;
	logic             q_pop;

	dei_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.cfg    (cfg),
		.q_wr   (q_wr),
		.q_full (q_full)
	);

	dei_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_rd   (q_rd),
		.q_pop  (q_pop)
	);

	dei_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_rd   (q_rd),
		.q_pop  (q_pop),
		.tot    (tot)
	);

	// An accepted event always finds room in the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.ready) |-> !q_full)
		else $error("event accepted into a full queue");

	// The accumulator only pops segments that are present.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_rd.valid)
		else $error("queue popped while empty");

	// Energy only accrues together with counted seconds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(tot.valid && (tot.energy_uws != '0)) |-> (tot.session_seconds != '0))
		else $error("energy reported without counted seconds");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Discharge energy integrator testbench
// Drives power events and whole_ledger writes through the valid/ready
// channels, keeps a bit-accurate copy of the integrator state, and compares
// every totals transaction with the oldest expected one. A directed table
// comes first. A saturation burst and randomized phases, most of them with
// random idling on both sides, follow.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Unused kind codes, which the block treats as ticks.
	localparam dei_pkg::kind_t KIND_RSVD_A = 3'd5;
	localparam dei_pkg::kind_t KIND_RSVD_B = 3'd6;
	localparam dei_pkg::kind_t KIND_RSVD_C = 3'd7;

	localparam dei_pkg::pwr_t PWR_MIN  = 32'sh8000_0000;
	localparam dei_pkg::pwr_t PWR_MAX  = 32'sh7FFF_FFFF;
	localparam dei_pkg::ts_t  TS_LAST  = 32'hFFFF_FFFF;
	localparam dei_pkg::sec_t SEC_FULL = '1;
	localparam dei_pkg::en_t  EN_FULL  = '1;

	localparam int HOLDOFF_CYCLES   = 300;
	localparam int SAT_PAIRS        = 4;
	localparam int PHASES           = 4;
	localparam int EVENTS_PER_PHASE = 125;
	localparam int TX_PCT [PHASES]  = '{20, 0, 35, 10};
	localparam int RX_PCT [PHASES]  = '{20, 0, 35, 50};

	typedef enum logic {ROW_EVENT, ROW_LEDGER} row_op_t;

	typedef struct packed {
		dei_pkg::sec_t sec;
		dei_pkg::en_t  en;
	} totals_t;

	// One step of the directed plan; typed marks a hand-written expectation.
	typedef struct packed {
		row_op_t        op;
		logic           ledger;
		dei_pkg::kind_t kind;
		dei_pkg::ts_t   ts;
		dei_pkg::pwr_t  pw;
		logic           typed;
		totals_t        want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	dei_event_if  evt_ch ();
	dei_cfg_if    cfg_ch ();
	dei_totals_if tot_ch ();

	discharge_energy_integrator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.cfg    (cfg_ch),
		.tot    (tot_ch)
	);

	// Integrator state as the block should hold it.
	logic           ledger_whole = 1'b0;
	logic           prev_seen    = 1'b0;
	dei_pkg::kind_t last_kind    = dei_pkg::KIND_TICK;
	dei_pkg::ts_t   last_ts      = '0;
	dei_pkg::pwr_t  last_pwr     = '0;
	dei_pkg::sec_t  sec_acc      = '0;
	dei_pkg::en_t   en_acc       = '0;

	totals_t      totals_due [$];
	int           mismatch_count  = 0;
	int           tx_gap_pct      = 0;
	int           rx_stall_pct    = 0;
	bit           holdoff_request = 1'b0;
	dei_pkg::ts_t ts_cursor       = '0;
	plan_row_t    plan [21];

	// Clock.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int gap_length();
		if ($urandom_range(99) < 80)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Integrates one event into the predicted state and returns the new totals.
	function automatic totals_t integrate_event(dei_pkg::kind_t kind, dei_pkg::ts_t ts,
			dei_pkg::pwr_t pw);
		logic [48:0] sec_sum;
		logic [63:0] en_sum;
		logic [31:0] dt;
		logic [31:0] mag;
		totals_t     res;
		if (prev_seen && last_kind != dei_pkg::KIND_SLEEP &&
				last_kind != dei_pkg::KIND_PLUG &&
				kind != dei_pkg::KIND_WAKE && ts > last_ts) begin
			dt = ts - last_ts;
			sec_sum = {1'b0, sec_acc} + 49'(dt);
			sec_acc = sec_sum[48] ? SEC_FULL : sec_sum[47:0];
			if (last_pwr < 0) begin
				mag = -last_pwr;
				en_sum = {1'b0, en_acc} + 64'(mag) * 64'(dt);
				en_acc = (en_sum > {1'b0, EN_FULL}) ? EN_FULL : en_sum[62:0];
			end
		end
		// An unplug closes the session unless the whole ledger is integrated.
		if (kind == dei_pkg::KIND_UNPLUG && !ledger_whole) begin
			sec_acc = '0;
			en_acc  = '0;
		end
		prev_seen = 1'b1;
		last_kind = kind;
		last_ts   = ts;
		last_pwr  = pw;
		res.sec = sec_acc;
		res.en  = en_acc;
		return res;
	endfunction

	// Offers one event and records its expected totals once it is accepted.
	task automatic send_event(input dei_pkg::kind_t kind, input dei_pkg::ts_t ts,
			input dei_pkg::pwr_t pw, input logic use_typed = 1'b0,
			input totals_t typed = '0);
		totals_t predicted;
		if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
			evt_ch.valid <= 1'b0;
			repeat (gap_length()) @(posedge clk);
		end
		evt_ch.valid      <= 1'b1;
		evt_ch.event_kind <= kind;
		evt_ch.timestamp  <= ts;
		evt_ch.power_uw   <= pw;
		do @(posedge clk); while (!evt_ch.ready);
		predicted = integrate_event(kind, ts, pw);
		totals_due.push_back(use_typed ? typed : predicted);
	endtask

	// Writes the mode register once the block has drained.
	task automatic write_ledger(input logic value);
		evt_ch.valid <= 1'b0;
		while (totals_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.whole_ledger <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		ledger_whole = value;
	endtask

	// Random event: mostly a session with rising time, some noise mixed in.
	task automatic send_random_event();
		int             sel;
		dei_pkg::kind_t kind;
		dei_pkg::pwr_t  pw;
		sel = $urandom_range(99);
		if (sel < 55)      kind = dei_pkg::KIND_TICK;
		else if (sel < 65) kind = dei_pkg::KIND_UNPLUG;
		else if (sel < 73) kind = dei_pkg::KIND_PLUG;
		else if (sel < 81) kind = dei_pkg::KIND_SLEEP;
		else if (sel < 89) kind = dei_pkg::KIND_WAKE;
		else kind = dei_pkg::kind_t'($urandom_range(KIND_RSVD_C, KIND_RSVD_A));

		sel = $urandom_range(99);
		if (sel < 70)      ts_cursor = ts_cursor + $urandom_range(600, 0);
		else if (sel < 85) ts_cursor = ts_cursor + $urandom_range(2_000_000, 0);
		else if (sel < 93) ts_cursor = ts_cursor - $urandom_range(50, 1);
		else               ts_cursor = $urandom;

		sel = $urandom_range(99);
		if (sel < 40)      pw = -dei_pkg::pwr_t'($urandom_range(5_000_000, 1));
		else if (sel < 60) pw = dei_pkg::pwr_t'($urandom_range(5_000_000, 1));
		else if (sel < 80) pw = $urandom;
		else if (sel < 90) pw = '0;
		else begin
			case ($urandom_range(2))
				0: pw = PWR_MIN;
				1: pw = PWR_MAX;
				default: pw = -1;
			endcase
		end
		send_event(kind, ts_cursor, pw);
	endtask

	// Totals sink: random stalls, plus one long hold-off on request.
	initial begin : totals_sink
		int idle_left;
		idle_left = 0;
		tot_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_request) begin
				holdoff_request = 1'b0;
				idle_left = HOLDOFF_CYCLES;
			end else if (idle_left == 0 && rx_stall_pct != 0 &&
					$urandom_range(99) < rx_stall_pct) begin
				idle_left = gap_length();
			end
			if (idle_left != 0) begin
				tot_ch.ready <= 1'b0;
				idle_left--;
			end else begin
				tot_ch.ready <= 1'b1;
			end
		end
	end

	// Compares each totals transaction with the oldest expectation.
	always @(posedge clk) begin
		totals_t want;
		if (arst_n && tot_ch.valid && tot_ch.ready) begin
			if (totals_due.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: unexpected totals transaction: expected none, got %0d / %0d",
					$time, tot_ch.session_seconds, tot_ch.energy_uws);
			end else begin
				want = totals_due.pop_front();
				if (tot_ch.session_seconds !== want.sec) begin
					mismatch_count++;
					$display("%0t ns: session_seconds mismatch: expected %0d, got %0d",
						$time, want.sec, tot_ch.session_seconds);
				end
				if (tot_ch.energy_uws !== want.en) begin
					mismatch_count++;
					$display("%0t ns: energy_uws mismatch: expected %0d, got %0d",
						$time, want.en, tot_ch.energy_uws);
				end
			end
		end
	end

	// Stimulus.
	initial begin : stimulus
		int phase;
		int n;
		arst_n = 1'b0;
		evt_ch.valid        <= 1'b0;
		evt_ch.event_kind   <= dei_pkg::KIND_TICK;
		evt_ch.timestamp    <= '0;
		evt_ch.power_uw     <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.whole_ledger <= 1'b0;

		// Directed plan, starting from the reset mode (totals clear at unplug).
		plan[0]  = '{ROW_EVENT, 1'b0, dei_pkg::KIND_TICK,   32'd100, -32'sd1000, 1'b1,
			'{48'd0, 63'd0}};
		plan[1]  = '{ROW_EVENT, 1'b0, dei_pkg::KIND_TICK,   32'd110, 32'sd0, 1'b1,
			'{48'd10, 63'd10000}};
		plan[2]  = '{ROW_EVENT, 1'b0, dei_pkg::KIND_SLEEP,  32'd120, -32'sd5, 1'b1,
			'{48'd20, 63'd10000}};
		plan[3]  = '{ROW_EVENT, 1'b0, dei_pkg::KIND_WAKE,   32'd500, -32'sd5, 1'b1,
			'{48'd20, 63'd10000}};
		plan[4]  = '{ROW_EVENT, 1'b0, dei_pkg::KIND_TICK,   32'd510, PWR_MIN, 1'b1,
			'{48'd30, 63'd10050}};
		plan[5]  = '{ROW_EVENT, 1'b0, dei_pkg::KIND_PLUG,   32'd520, 32'sd7, 1'b1,
			'{48'd40, 63'd21474846530}};
		plan[6]  = '{ROW_EVENT, 1'b0, dei_pkg::KIND_TICK,   32'd600, 32'sd3, 1'b1,
			'{48'd40, 63'd21474846530}};
		plan[7]  = '{ROW_EVENT, 1'b0, KIND_RSVD_A,          32'd590, -32'sd1, 1'b1,
			'{48'd40, 63'd21474846530}};
		plan[8]  = '{ROW_EVENT, 1'b0, dei_pkg::KIND_TICK,   32'd590, -32'sd1, 1'b1,
			'{48'd40, 63'd21474846530}};
		plan[9]  = '{ROW_EVENT, 1'b0, dei_pkg::KIND_UNPLUG, 32'd600, -32'sd2, 1'b1,
			'{48'd0, 63'd0}};
		plan[10] = '{ROW_EVENT, 1'b0, dei_pkg::KIND_TICK,   TS_LAST, PWR_MAX, 1'b0, '0};
		plan[11] = '{ROW_EVENT, 1'b0, KIND_RSVD_B,          32'd0, PWR_MIN, 1'b0, '0};
		plan[12] = '{ROW_EVENT, 1'b0, KIND_RSVD_C,          TS_LAST, -32'sd1, 1'b0, '0};
		plan[13] = '{ROW_EVENT, 1'b0, dei_pkg::KIND_WAKE,   TS_LAST, -32'sd1, 1'b0, '0};
		plan[14] = '{ROW_LEDGER, 1'b1, dei_pkg::KIND_TICK,  '0, '0, 1'b0, '0};
		plan[15] = '{ROW_EVENT, 1'b0, dei_pkg::KIND_TICK,   32'd10, -32'sd3, 1'b0, '0};
		plan[16] = '{ROW_EVENT, 1'b0, dei_pkg::KIND_UNPLUG, 32'd20, 32'sd5, 1'b0, '0};
		plan[17] = '{ROW_EVENT, 1'b0, dei_pkg::KIND_TICK,   32'd30, 32'sd0, 1'b0, '0};
		plan[18] = '{ROW_LEDGER, 1'b0, dei_pkg::KIND_TICK,  '0, '0, 1'b0, '0};
		plan[19] = '{ROW_EVENT, 1'b0, dei_pkg::KIND_UNPLUG, 32'd40, 32'sd0, 1'b1,
			'{48'd0, 63'd0}};
		plan[20] = '{ROW_EVENT, 1'b0, dei_pkg::KIND_TICK,   32'd50, 32'sd0, 1'b1,
			'{48'd10, 63'd0}};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_gap_pct   = 15;
		rx_stall_pct = 15;
		foreach (plan[i]) begin
			if (plan[i].op == ROW_LEDGER)
				write_ledger(plan[i].ledger);
			else
				send_event(plan[i].kind, plan[i].ts, plan[i].pw, plan[i].typed,
					plan[i].want);
		end

		// Drive the energy total into saturation with maximal segments at full rate.
		write_ledger(1'b1);
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		for (n = 0; n < SAT_PAIRS; n++) begin
			send_event(dei_pkg::KIND_TICK, '0, PWR_MIN);
			send_event(dei_pkg::KIND_TICK, TS_LAST, PWR_MIN);
		end

		// Random phases, alternating the mode register.
		for (phase = 0; phase < PHASES; phase++) begin
			write_ledger(phase[0]);
			tx_gap_pct   = TX_PCT[phase];
			rx_stall_pct = RX_PCT[phase];
			for (n = 0; n < EVENTS_PER_PHASE; n++) begin
				// Long sink hold-off while events keep coming back to back.
				if (phase == 1 && n == 20)
					holdoff_request = 1'b1;
				// Sender pause until every pending result has drained.
				if (phase == 2 && n == 60) begin
					evt_ch.valid <= 1'b0;
					while (totals_due.size() != 0) @(posedge clk);
				end
				send_random_event();
			end
		end

		evt_ch.valid <= 1'b0;
		while (totals_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Run limit.
	initial begin : watchdog
		#10ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/dei_pkg.sv
sv/dei_if.sv
sv/dei_front.sv
sv/dei_fifo.sv
sv/dei_back.sv
sv/discharge_energy_integrator.sv
bench/tb_top.sv
